FILE: hw/rtl/hed_pkg.sv
// hed_pkg: shared types, constants and entity tables for the HTML entity decoder.
// Used by hed_front, hed_queue, hed_back and html_entity_decoder; no dependencies.
`timescale 1ns / 1ps

package hed_pkg;

    // entity codes
    localparam logic [1:0] ENT_AMP  = 2'd0;
    localparam logic [1:0] ENT_GT   = 2'd1;
    localparam logic [1:0] ENT_LT   = 2'd2;
    localparam logic [1:0] ENT_QUOT = 2'd3;

    localparam logic [7:0] CH_AMP  = 8'h26; // &
    localparam logic [7:0] CH_GT   = 8'h3e; // >
    localparam logic [7:0] CH_LT   = 8'h3c; // <
    localparam logic [7:0] CH_QUOT = 8'h22; // "
    localparam logic [7:0] CH_SEMI = 8'h3b; // ;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_L    = 8'h6c;
    localparam logic [7:0] CH_M    = 8'h6d;
    localparam logic [7:0] CH_O    = 8'h6f;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_U    = 8'h75;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one classified input word: replay letters, then an optional tail byte
    typedef struct packed {
        logic [2:0] rep_n;     // entity letters to replay (0..4)
        logic [1:0] pick;      // entity whose letters are replayed
        logic       tail_vld;  // a tail byte follows the replay
        logic [7:0] tail_byte;
        logic       last;      // string ends with this command
    } t_cmd;

    // letters after the ampersand; zero past the end
    function automatic logic [7:0] ent_letter(input logic [1:0] pick, input logic [2:0] idx);
        logic [7:0] r;
        r = 8'h00;
        unique case (pick)
            ENT_AMP: begin
                unique case (idx)
                    3'd0: r = CH_A;
                    3'd1: r = CH_M;
                    3'd2: r = CH_P;
                    3'd3: r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
            ENT_GT: begin
                unique case (idx)
                    3'd0: r = CH_G;
                    3'd1: r = CH_T;
                    3'd2: r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
            ENT_LT: begin
                unique case (idx)
                    3'd0: r = CH_L;
                    3'd1: r = CH_T;
                    3'd2: r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd0: r = CH_Q;
                    3'd1: r = CH_U;
                    3'd2: r = CH_O;
                    3'd3: r = CH_T;
                    3'd4: r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ent_len(input logic [1:0] pick);
        logic [2:0] r;
        unique case (pick)
            ENT_AMP:  r = 3'd4;
            ENT_GT:   r = 3'd3;
            ENT_LT:   r = 3'd3;
            default:  r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_char(input logic [1:0] pick);
        logic [7:0] r;
        unique case (pick)
            ENT_AMP:  r = CH_AMP;
            ENT_GT:   r = CH_GT;
            ENT_LT:   r = CH_LT;
            default:  r = CH_QUOT;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/html_entity_decoder.sv
// html_entity_decoder: streaming decoder for &amp; &gt; &lt; &quot;, one byte word per
// cycle while o_stall is low. The first output word passes through the command queue and
// the output register. Input words are taken one per cycle while each yields at most one
// output word; the back emits one output word per cycle while i_stall is low, so a word
// yielding up to 5 words keeps the back busy longer, absorbed by the 4-entry command queue.
// Synchronous active-low reset clears match state, queue and output valid; no clearing pass.
`timescale 1ns / 1ps

module html_entity_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_run_last,
    output logic       o_string_end
);

    logic          w_push;
    hed_pkg::t_cmd w_push_cmd;
    logic          w_pop;
    logic          w_q_full;
    logic          w_head_vld;
    hed_pkg::t_cmd w_head;

    assign o_stall = w_q_full;

    hed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    hed_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_push_cmd),
        .i_pop      (w_pop),
        .o_full     (w_q_full),
        .o_head_vld (w_head_vld),
        .o_head     (w_head)
    );

    hed_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_vld   (w_head_vld),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_has_byte   (o_has_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_end |-> o_run_last)
        else $error("string end without run last");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_run_last && o_string_end && o_out_byte == 8'h00)
        else $error("bare marker malformed");

    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> w_head_vld)
        else $error("queue full but empty head");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !w_head_vld)
        else $error("output or queue active after reset");

endmodule

FILE: hw/rtl/hed_front.sv
// hed_front: accepts input words, tracks the open entity match and issues commands.
// Depends on hed_pkg.
`timescale 1ns / 1ps

module hed_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    input  logic           i_last_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output hed_pkg::t_cmd  o_cmd
);

    logic       r_after_amp;
    logic [1:0] r_pick;
    logic [2:0] r_cnt;
    logic       n_after_amp;
    logic [1:0] n_pick;
    logic [2:0] n_cnt;

    logic       w_accept;
    logic       w_plain;
    logic       w_first_hit;
    logic [1:0] w_first_pick;
    logic [2:0] w_cnt_inc;
    hed_pkg::t_cmd w_cmd;

    assign w_accept  = i_valid && !i_q_full;
    assign w_cnt_inc = 3'(r_cnt + 3'd1);

    always_comb begin
        w_first_hit  = 1'b1;
        w_first_pick = hed_pkg::ENT_AMP;
        priority if (i_in_byte == hed_pkg::CH_A) w_first_pick = hed_pkg::ENT_AMP;
        else if (i_in_byte == hed_pkg::CH_G)     w_first_pick = hed_pkg::ENT_GT;
        else if (i_in_byte == hed_pkg::CH_L)     w_first_pick = hed_pkg::ENT_LT;
        else if (i_in_byte == hed_pkg::CH_Q)     w_first_pick = hed_pkg::ENT_QUOT;
        else                                     w_first_hit  = 1'b0;
    end

    always_comb begin
        n_after_amp     = r_after_amp;
        n_pick          = r_pick;
        n_cnt           = r_cnt;
        w_plain         = 1'b0;
        w_cmd.rep_n     = 3'd0;
        w_cmd.pick      = r_pick;
        w_cmd.tail_vld  = 1'b0;
        w_cmd.tail_byte = i_in_byte;
        w_cmd.last      = i_last_byte;

        if (!r_after_amp) begin
            w_plain = 1'b1;
        end else if (r_cnt == 3'd0) begin
            if (w_first_hit) begin
                n_pick     = w_first_pick;
                n_cnt      = 3'd1;
                w_cmd.pick = w_first_pick;
                if (i_last_byte) w_cmd.rep_n = 3'd1;
            end else begin
                n_after_amp = 1'b0;
                n_pick      = 2'd0;
                n_cnt       = 3'd0;
                w_plain     = 1'b1;
            end
        end else begin
            if (r_cnt < hed_pkg::ent_len(r_pick) &&
                i_in_byte == hed_pkg::ent_letter(r_pick, r_cnt)) begin
                if (w_cnt_inc == hed_pkg::ent_len(r_pick)) begin
                    w_cmd.tail_vld  = 1'b1;
                    w_cmd.tail_byte = hed_pkg::ent_char(r_pick);
                    n_after_amp     = 1'b0;
                    n_pick          = 2'd0;
                    n_cnt           = 3'd0;
                end else begin
                    n_cnt = w_cnt_inc;
                    if (i_last_byte) w_cmd.rep_n = w_cnt_inc;
                end
            end else begin
                // mismatch: replay what matched, then treat the byte as plain
                w_cmd.rep_n = r_cnt;
                n_after_amp = 1'b0;
                n_pick      = 2'd0;
                n_cnt       = 3'd0;
                w_plain     = 1'b1;
            end
        end

        if (w_plain) begin
            if (i_in_byte == hed_pkg::CH_AMP) begin
                if (!i_last_byte) begin
                    n_after_amp = 1'b1;
                    n_pick      = 2'd0;
                    n_cnt       = 3'd0;
                end
            end else begin
                w_cmd.tail_vld = 1'b1;
            end
        end

        if (i_last_byte) begin
            n_after_amp = 1'b0;
            n_pick      = 2'd0;
            n_cnt       = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_amp <= 1'b0;
            r_pick      <= 2'd0;
            r_cnt       <= 3'd0;
        end else if (w_accept) begin
            r_after_amp <= n_after_amp;
            r_pick      <= n_pick;
            r_cnt       <= n_cnt;
        end
    end

    // words that produce nothing and do not end the string need no command
    assign o_push = w_accept && (w_cmd.rep_n != 3'd0 || w_cmd.tail_vld || w_cmd.last);
    assign o_cmd  = w_cmd;

endmodule

FILE: hw/rtl/hed_queue.sv
// hed_queue: short command FIFO between the front and the back.
// Depends on hed_pkg (t_cmd, Q_DEPTH, Q_AW).
`timescale 1ns / 1ps

module hed_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hed_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_vld,
    output hed_pkg::t_cmd  o_head
);

    localparam int AW = hed_pkg::Q_AW;

    hed_pkg::t_cmd r_mem [hed_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full     = r_count == (AW+1)'(hed_pkg::Q_DEPTH);
    assign o_head_vld = r_count != '0;
    assign o_head     = r_mem[r_rd_ptr];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) r_wr_ptr <= AW'(r_wr_ptr + 1'b1);
            if (w_do_pop)  r_rd_ptr <= AW'(r_rd_ptr + 1'b1);
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= (AW+1)'(r_count + 1'b1);
                2'b01:   r_count <= (AW+1)'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/hed_back.sv
// hed_back: expands commands into registered output words, one per cycle unless stalled.
// Depends on hed_pkg.
`timescale 1ns / 1ps

module hed_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_vld,
    input  hed_pkg::t_cmd  i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_has_byte,
    output logic           o_run_last,
    output logic           o_string_end
);

    logic [2:0] r_pos;
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_has_byte;
    logic       r_run_last;
    logic       r_string_end;

    logic [2:0] w_total;
    logic [2:0] w_end_pos;
    logic       w_word_last;
    logic [7:0] w_byte;
    logic       w_load;
    logic       w_advance;

    assign w_total     = 3'(i_head.rep_n + {2'b00, i_head.tail_vld});
    // an empty command still carries the bare end marker
    assign w_end_pos   = (w_total == 3'd0) ? 3'd0 : 3'(w_total - 3'd1);
    assign w_word_last = r_pos == w_end_pos;
    assign w_advance   = !r_out_vld || !i_stall;
    assign w_load      = i_head_vld && w_advance;

    always_comb begin
        if (r_pos < i_head.rep_n) w_byte = hed_pkg::ent_letter(i_head.pick, r_pos);
        else if (i_head.tail_vld) w_byte = i_head.tail_byte;
        else                      w_byte = 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_advance) r_out_vld <= i_head_vld;
            if (w_load)    r_pos <= w_word_last ? 3'd0 : 3'(r_pos + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte   <= w_byte;
            r_has_byte   <= w_total != 3'd0;
            r_run_last   <= w_word_last;
            r_string_end <= w_word_last && i_head.last;
        end
    end

    assign o_pop        = w_load && w_word_last;
    assign o_valid      = r_out_vld;
    assign o_out_byte   = r_out_byte;
    assign o_has_byte   = r_has_byte;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_string_end;

endmodule
